// ===== sv/mlsd_pkg.sv =====
// Shared types and constants for the magic-length stream deframer.
package mlsd_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // result kinds
   localparam logic [2:0] KIND_TEXT  = 3'd0;
   localparam logic [2:0] KIND_EOL   = 3'd1;
   localparam logic [2:0] KIND_BODY  = 3'd2;
   localparam logic [2:0] KIND_FINAL = 3'd3;
   localparam logic [2:0] KIND_EMPTY = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_START_ONE   = 2'd0;
   localparam logic [1:0] CSR_START_TWO   = 2'd1;
   localparam logic [1:0] CSR_FRAME_LIMIT = 2'd2;
   localparam logic [1:0] CSR_LINE_LIMIT  = 2'd3;

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_SECOND = 3'd1,
      PH_LEN_HI = 3'd2,
      PH_LEN_LO = 3'd3,
      PH_BODY   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      EVT_TEXT  = 2'd0,
      EVT_EMPTY = 2'd1,
      EVT_BODY  = 2'd2,
      EVT_FINAL = 2'd3
   } evt_type;

   typedef struct packed {
      logic [7:0]  start_one;
      logic [7:0]  start_two;
      logic [15:0] frame_limit;
      logic [7:0]  line_limit;
   } cfg_type;

   // One classified input byte: either a frame event or up to two text bytes.
   typedef struct packed {
      evt_type     evt;
      logic [1:0]  text_n;
      logic [7:0]  text0;
      logic [7:0]  text1;
      logic [7:0]  data;
      logic [15:0] len;
      logic [31:0] frames;
      logic [31:0] resyncs;
   } cmd_type;

endpackage

// ===== sv/mlsd_front.sv =====
// Header parser: tracks framing state and classifies each byte into a command.
module mlsd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_byte_in,
   input  mlsd_pkg::cfg_type cfg,
   input  logic             q_ready,
   output logic             q_push,
   output mlsd_pkg::cmd_type q_cmd
);
   import mlsd_pkg::*;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] n;
      logic [7:0] t0;
      logic [7:0] t1;
   } hunt_type;

   function automatic hunt_type hunt(phase_type ph, logic [7:0] b,
                                     logic [7:0] s1, logic [7:0] s2);
      hunt_type r;
      r = '{phase: PH_HUNT, n: 2'd0, t0: 8'h00, t1: 8'h00};
      if (ph == PH_SECOND) begin
         if (b == s2) begin
            r.phase = PH_LEN_HI;
         end else if (b == s1) begin
            r.phase = PH_SECOND;
            r.n     = 2'd1;
            r.t0    = s1;
         end else begin
            r.n  = 2'd2;
            r.t0 = s1;
            r.t1 = b;
         end
      end else if (b == s1) begin
         r.phase = PH_SECOND;
      end else begin
         r.n  = 2'd1;
         r.t0 = b;
      end
      return r;
   endfunction

   phase_type               phase_ff, phase_in;
   logic [15:0]             len_ff, len_in;
   logic [15:0]             body_ff, body_in;
   logic [COUNT_WIDTH-1:0]  frames_ff, frames_in;
   logic [COUNT_WIDTH-1:0]  resyncs_ff, resyncs_in;

   logic        accept;
   logic [15:0] len_full;
   logic [15:0] body_nx;
   logic        oversize;
   hunt_type    hs, h1, h2;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   assign len_full  = {len_ff[15:8], req_byte_in};
   assign oversize  = len_full > cfg.frame_limit;
   assign body_nx   = body_ff + 16'd1;

   assign hs = hunt(phase_ff, req_byte_in, cfg.start_one, cfg.start_two);
   // oversize length: both length bytes go back through the hunt
   assign h1 = hunt(PH_HUNT, len_ff[15:8], cfg.start_one, cfg.start_two);
   assign h2 = hunt(h1.phase, req_byte_in, cfg.start_one, cfg.start_two);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      len_in     = len_ff;
      body_in    = body_ff;
      frames_in  = frames_ff;
      resyncs_in = resyncs_ff;
      if (accept) begin
         case (phase_ff)
            PH_LEN_HI: begin
               len_in   = {req_byte_in, 8'h00};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len_in = len_full;
               if (oversize) begin
                  resyncs_in = resyncs_ff + COUNT_WIDTH'(1);
                  phase_in   = h2.phase;
               end else if (len_full == 16'd0) begin
                  frames_in = frames_ff + COUNT_WIDTH'(1);
                  phase_in  = PH_HUNT;
               end else begin
                  body_in  = 16'd0;
                  phase_in = PH_BODY;
               end
            end
            PH_BODY: begin
               body_in = body_nx;
               if (body_nx == len_ff) begin
                  frames_in = frames_ff + COUNT_WIDTH'(1);
                  phase_in  = PH_HUNT;
               end
            end
            default: begin
               phase_in = hs.phase;
            end
         endcase
      end
   end

   // command
   always_comb begin
      q_cmd.evt     = EVT_TEXT;
      q_cmd.text_n  = 2'd0;
      q_cmd.text0   = 8'h00;
      q_cmd.text1   = 8'h00;
      q_cmd.data    = req_byte_in;
      q_cmd.len     = len_ff;
      q_cmd.frames  = 32'(frames_in);
      q_cmd.resyncs = 32'(resyncs_in);
      case (phase_ff)
         PH_LEN_HI: begin
         end
         PH_LEN_LO: begin
            if (oversize) begin
               q_cmd.text_n = h1.n + h2.n;
               q_cmd.text0  = (h1.n != 2'd0) ? h1.t0 : h2.t0;
               q_cmd.text1  = (h1.n != 2'd0) ? h2.t0 : h2.t1;
            end else if (len_full == 16'd0) begin
               q_cmd.evt  = EVT_EMPTY;
               q_cmd.data = 8'h00;
               q_cmd.len  = 16'd0;
            end
         end
         PH_BODY: begin
            q_cmd.evt = (body_nx == len_ff) ? EVT_FINAL : EVT_BODY;
         end
         default: begin
            q_cmd.text_n = hs.n;
            q_cmd.text0  = hs.t0;
            q_cmd.text1  = hs.t1;
         end
      endcase
      q_push = accept && ((q_cmd.evt != EVT_TEXT) || (q_cmd.text_n != 2'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         len_ff     <= '0;
         body_ff    <= '0;
         frames_ff  <= '0;
         resyncs_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         body_ff    <= body_in;
         frames_ff  <= frames_in;
         resyncs_ff <= resyncs_in;
      end
   end

endmodule

// ===== sv/mlsd_cmd_queue.sv =====
// Short first-word-fall-through command queue between parser and emitter.
module mlsd_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mlsd_pkg::cmd_type push_cmd,
   output logic              ready,
   output logic              head_valid,
   output mlsd_pkg::cmd_type head_cmd,
   input  logic              pop
);
   import mlsd_pkg::*;

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign ready      = count_ff != QCNT_WIDTH'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_WIDTH'(1);
         if (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) wr_ptr_in = '0;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_WIDTH'(1);
         if (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) rd_ptr_in = '0;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/mlsd_back.sv =====
// Emitter: expands commands into result beats, handles console text and line ends.
module mlsd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [7:0]        line_limit,
   input  logic              q_valid,
   input  mlsd_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_kind,
   output logic [7:0]        rsp_data,
   output logic [15:0]       rsp_frame_len,
   output logic [31:0]       rsp_frames_total,
   output logic [31:0]       rsp_resyncs_total,
   output logic [31:0]       rsp_text_total,
   output logic              rsp_last
);
   import mlsd_pkg::*;

   logic                   tidx_ff, tidx_in;
   logic                   pend_ff, pend_in;     // line end owed after a full line
   logic [COUNT_WIDTH-1:0] text_cnt_ff, text_cnt_in;
   logic [7:0]             line_cnt_ff, line_cnt_in;

   logic                   valid_ff, valid_in;
   logic [2:0]             kind_ff, kind_in;
   logic [7:0]             data_ff, data_in;
   logic [15:0]            len_ff, len_in;
   logic [31:0]            frames_ff, frames_in;
   logic [31:0]            resyncs_ff, resyncs_in;
   logic [31:0]            text_ff, text_in;
   logic                   last_ff, last_in;

   logic       out_ok, step, emit, advance, is_end, next_quiet;
   logic [7:0] cur_byte;
   logic [7:0] line_nx;

   assign out_ok     = !valid_ff || rsp_ready;
   assign step       = q_valid && out_ok;
   assign cur_byte   = tidx_ff ? q_cmd.text1 : q_cmd.text0;
   assign is_end     = tidx_ff || (q_cmd.text_n == 2'd1);
   // a trailing CR gives no beat, so the current beat is the last one
   assign next_quiet = is_end || (q_cmd.text1 == CHAR_CR);
   assign line_nx    = line_cnt_ff + 8'd1;

   always_comb begin
      emit        = 1'b0;
      advance     = 1'b0;
      q_pop       = 1'b0;
      tidx_in     = tidx_ff;
      pend_in     = pend_ff;
      text_cnt_in = text_cnt_ff;
      line_cnt_in = line_cnt_ff;
      kind_in     = KIND_TEXT;
      data_in     = 8'h00;
      len_in      = 16'd0;
      last_in     = 1'b0;
      if (step) begin
         if (q_cmd.evt != EVT_TEXT) begin
            emit    = 1'b1;
            q_pop   = 1'b1;
            last_in = 1'b1;
            data_in = q_cmd.data;
            len_in  = q_cmd.len;
            unique case (q_cmd.evt)
               EVT_EMPTY: kind_in = KIND_EMPTY;
               EVT_BODY:  kind_in = KIND_BODY;
               EVT_FINAL: kind_in = KIND_FINAL;
               EVT_TEXT:  kind_in = KIND_TEXT;
            endcase
         end else if (pend_ff) begin
            emit    = 1'b1;
            kind_in = KIND_EOL;
            advance = 1'b1;
            last_in = next_quiet;
         end else begin
            text_cnt_in = text_cnt_ff + COUNT_WIDTH'(1);
            if (cur_byte == CHAR_CR) begin
               advance = 1'b1;
            end else if (cur_byte == CHAR_LF) begin
               emit        = 1'b1;
               kind_in     = KIND_EOL;
               line_cnt_in = 8'd0;
               advance     = 1'b1;
               last_in     = next_quiet;
            end else begin
               emit    = 1'b1;
               kind_in = KIND_TEXT;
               data_in = cur_byte;
               if (line_nx >= line_limit) begin
                  line_cnt_in = 8'd0;
                  pend_in     = 1'b1;
               end else begin
                  line_cnt_in = line_nx;
                  advance     = 1'b1;
                  last_in     = next_quiet;
               end
            end
         end
         if (advance) begin
            pend_in = 1'b0;
            if (is_end) begin
               q_pop   = 1'b1;
               tidx_in = 1'b0;
            end else begin
               tidx_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      valid_in   = valid_ff;
      frames_in  = frames_ff;
      resyncs_in = resyncs_ff;
      text_in    = text_ff;
      if (step && emit) begin
         valid_in   = 1'b1;
         frames_in  = q_cmd.frames;
         resyncs_in = q_cmd.resyncs;
         text_in    = 32'(text_cnt_in);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         len_ff  <= len_in;
         last_ff <= last_in;
      end
      frames_ff  <= frames_in;
      resyncs_ff <= resyncs_in;
      text_ff    <= text_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tidx_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         text_cnt_ff <= '0;
         line_cnt_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         tidx_ff     <= tidx_in;
         pend_ff     <= pend_in;
         text_cnt_ff <= text_cnt_in;
         line_cnt_ff <= line_cnt_in;
         valid_ff    <= valid_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_data          = data_ff;
   assign rsp_frame_len     = len_ff;
   assign rsp_frames_total  = frames_ff;
   assign rsp_resyncs_total = resyncs_ff;
   assign rsp_text_total    = text_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== sv/magic_length_stream_deframer.sv =====
// Top level of the magic-length stream deframer: registers and part wiring.
//
// req_* carries one received byte per beat (valid/ready). rsp_* carries result
// beats: text chars, line ends, frame body bytes (final one marked), empty-frame
// events, each with snapshots of the frame, resync and text totals; rsp_last
// marks the final beat caused by one input byte. A byte may cause zero to four
// beats.
// csr_* writes the start bytes, frame limit and line limit; write only while idle.
//
// The parser classifies a byte in the cycle it is accepted and pushes a command
// into a two-entry queue; the emitter turns each command into beats, one beat
// per cycle while rsp_ready allows, into an output register. At the earliest,
// the first beat of a byte is presented after it passes the queue entry and
// the output register. Throughput is one byte per cycle while each byte gives
// at most one beat or dropped CR and rsp_ready stays high; a command holds the
// emitter for each beat and dropped CR; the queue then backs up into req_ready.
// A stalled rsp_ready holds the output register; the queue fills and req_ready
// drops. Synchronous reset returns to hunting, clears counters and the queue,
// and restores the register defaults.
module magic_length_stream_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data,
   output logic [15:0] rsp_frame_len,
   output logic [31:0] rsp_frames_total,
   output logic [31:0] rsp_resyncs_total,
   output logic [31:0] rsp_text_total,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import mlsd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic    q_push, q_ready, q_valid, q_pop;
   cmd_type push_cmd, head_cmd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_ONE:   cfg_in.start_one   = csr_wdata[7:0];
            CSR_START_TWO:   cfg_in.start_two   = csr_wdata[7:0];
            CSR_FRAME_LIMIT: cfg_in.frame_limit = csr_wdata;
            CSR_LINE_LIMIT:  cfg_in.line_limit  = csr_wdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{start_one: 8'd148, start_two: 8'd195,
                     frame_limit: 16'd512, line_limit: 8'd128};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mlsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .cfg         (cfg_ff),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   mlsd_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .ready      (q_ready),
      .head_valid (q_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop)
   );

   mlsd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .line_limit        (cfg_ff.line_limit),
      .q_valid           (q_valid),
      .q_cmd             (head_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_data          (rsp_data),
      .rsp_frame_len     (rsp_frame_len),
      .rsp_frames_total  (rsp_frames_total),
      .rsp_resyncs_total (rsp_resyncs_total),
      .rsp_text_total    (rsp_text_total),
      .rsp_last          (rsp_last)
   );

endmodule
